@@ rtl/cbd_pkg.sv @@
package cbd_pkg;

  localparam int unsigned SIZE_BITS_DEF = 32;

  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_TAB = 8'h09;
  localparam logic [7:0] CHR_VT  = 8'h0B;
  localparam logic [7:0] CHR_FF  = 8'h0C;
  localparam logic [7:0] CHR_SP  = 8'h20;

  typedef enum logic [6:0] {
    PH_LSTART = 7'b0000001,
    PH_WS     = 7'b0000010,
    PH_DIGITS = 7'b0000100,
    PH_REST   = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_TRAIL  = 7'b0100000,
    PH_DONE   = 7'b1000000
  } cbd_phase_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_NOLINEEND = 3'd3,
    ST_OVERFLOW  = 3'd4
  } cbd_status_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    cbd_status_e status;
  } cbd_result_t;

  // {is_digit, value}
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CHR_SP) || (b == CHR_TAB) || (b == CHR_CR) ||
           (b == CHR_VT) || (b == CHR_FF);
  endfunction

endpackage

@@ rtl/cbd_if.sv @@
interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       final_byte;

  modport source (output valid, output body_byte, output final_byte, input ready);
  modport sink   (input valid, input body_byte, input final_byte, output ready);
endinterface

interface cbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_valid;
  logic [2:0] status;

  modport source (output valid, output data_byte, output data_valid, output status,
                  input ready);
  modport sink   (input valid, input data_byte, input data_valid, input status,
                  output ready);
endinterface

@@ rtl/cbd_parse.sv @@
module cbd_parse import cbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic [7:0]           byte_i,
  input  logic                 fin_i,
  input  cbd_phase_e           phase_i,
  input  logic [SIZE_BITS-1:0] size_i,
  input  logic                 had_digit_i,
  output cbd_phase_e           phase_o,
  output logic [SIZE_BITS-1:0] size_o,
  output logic                 had_digit_o,
  output cbd_result_t          result_o
);

  logic [4:0]           hex;
  logic                 is_nl;
  logic                 is_sp;
  logic                 ovf;
  logic                 line_ends_body;
  logic [SIZE_BITS-1:0] size_shift;

  assign hex        = hex_digit(byte_i);
  assign is_nl      = (byte_i == CHR_LF);
  assign is_sp      = is_space(byte_i);
  assign ovf        = |size_i[SIZE_BITS-1 -: 4];
  assign size_shift = {size_i[SIZE_BITS-5:0], hex[3:0]};
  // size line ending with no digit or a zero size closes the body
  assign line_ends_body = !had_digit_i || (size_i == '0);

  always_comb begin
    cbd_phase_e           ph;
    logic [SIZE_BITS-1:0] sz;
    logic                 hd;
    cbd_status_e          st;
    logic                 dv;
    logic [7:0]           db;
    ph = phase_i;
    sz = size_i;
    hd = had_digit_i;
    st = ST_NONE;
    dv = 1'b0;
    db = 8'h00;

    case (phase_i)
      PH_LSTART: begin
        sz = '0;
        hd = 1'b0;
        if (is_nl) begin
          ph = PH_LSTART;
        end else if (is_sp) begin
          ph = PH_WS;
        end else if (hex[4]) begin
          sz = {{(SIZE_BITS-4){1'b0}}, hex[3:0]};
          hd = 1'b1;
          ph = PH_DIGITS;
        end else begin
          ph = PH_REST;
        end
      end
      PH_WS, PH_DIGITS, PH_REST: begin
        if (is_nl) begin
          if (line_ends_body) begin
            ph = PH_DONE;
            st = ST_COMPLETE;
          end else begin
            ph = PH_DATA;
          end
        end else if (phase_i == PH_REST) begin
          ph = PH_REST;
        end else if (phase_i == PH_WS && is_sp) begin
          ph = PH_WS;
        end else if (hex[4]) begin
          if (ovf) begin
            ph = PH_DONE;
            st = ST_OVERFLOW;
          end else begin
            sz = size_shift;
            hd = 1'b1;
            ph = PH_DIGITS;
          end
        end else begin
          ph = PH_REST;
        end
      end
      PH_DATA: begin
        dv = 1'b1;
        db = byte_i;
        sz = size_i - SIZE_BITS'(1);
        if (size_i == SIZE_BITS'(1)) ph = PH_TRAIL;
      end
      PH_TRAIL: begin
        if (is_nl) ph = PH_LSTART;
      end
      default: begin
        ph = PH_DONE;
      end
    endcase

    if (fin_i) begin
      case (ph)
        PH_WS, PH_DIGITS, PH_REST: begin
          st = (!hd || sz == '0) ? ST_COMPLETE : ST_TRUNCATED;
        end
        PH_DATA:   st = ST_TRUNCATED;
        PH_TRAIL:  st = (phase_i == PH_DATA) ? ST_NOLINEEND : ST_COMPLETE;
        PH_LSTART: st = ST_COMPLETE;
        default:   st = st;
      endcase
      ph = PH_LSTART;
      sz = '0;
      hd = 1'b0;
    end

    phase_o     = ph;
    size_o      = sz;
    had_digit_o = hd;
    result_o    = '{data_byte: db, data_valid: dv, status: st};
  end

endmodule

@@ rtl/chunked_body_decoder.sv @@
// Chunked body decoder: takes one body byte per item and returns exactly one
// result item per input item (payload byte with data_valid, and a status code).
// Throughput is one byte per clock with back-pressure honoured on both sides;
// each byte passes through an input register and then a result register. The
// rate is set by the update of the phase and size/remaining registers, whose
// next value is a SIZE_BITS-wide shift-in or decrement and compare.
// Bytes after completion or an error are ignored until the final flag, which
// returns the decoder to the start of a size line.
module chunked_body_decoder import cbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbd_in_if.sink    in_i,
  cbd_out_if.source out_o
);

  logic                 in_vld_q;
  logic [7:0]           in_byte_q;
  logic                 in_fin_q;
  logic                 out_vld_q;
  cbd_result_t          res_q;
  cbd_phase_e           phase_q;
  cbd_phase_e           phase_d;
  logic [SIZE_BITS-1:0] size_q;
  logic [SIZE_BITS-1:0] size_d;
  logic                 had_q;
  logic                 had_d;
  cbd_result_t          res_d;
  logic                 adv;
  logic                 fire;

  assign adv        = !out_vld_q || out_o.ready;
  assign fire       = in_vld_q && adv;
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.body_byte;
      in_fin_q  <= in_i.final_byte;
    end
  end

  cbd_parse #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parse (
    .byte_i      (in_byte_q),
    .fin_i       (in_fin_q),
    .phase_i     (phase_q),
    .size_i      (size_q),
    .had_digit_i (had_q),
    .phase_o     (phase_d),
    .size_o      (size_d),
    .had_digit_o (had_d),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LSTART;
      size_q    <= '0;
      had_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        size_q  <= size_d;
        had_q   <= had_d;
      end
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.data_byte  = res_q.data_byte;
  assign out_o.data_valid = res_q.data_valid;
  assign out_o.status     = res_q.status;

  a_fin_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_fin_q |=> phase_q == PH_LSTART && size_q == '0 && !had_q)
    else $error("final item did not return decoder to line start");

  a_data_owed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> size_q != '0)
    else $error("payload phase with nothing owed");

  a_payload_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.data_valid |->
      res_q.status == ST_NONE || res_q.status == ST_TRUNCATED ||
      res_q.status == ST_NOLINEEND)
    else $error("payload byte with an impossible status");

endmodule

@@ verif/cbd_decode_check.sv @@
`timescale 1ns / 100ps

module cbd_decode_check import cbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbd_in_if           in_mon_i,
  cbd_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  cbd_phase_e           ph;
  logic [SIZE_BITS-1:0] count_q;    // gathered size on a size line, bytes owed in payload
  logic                 had_digit;
  cbd_result_t          decoded_q[$];
  cbd_result_t          want;
  int unsigned          fails;

  function automatic cbd_status_e close_size_line();
    if (!had_digit || count_q == '0) begin
      ph = PH_DONE;
      return ST_COMPLETE;
    end
    ph = PH_DATA;
    return ST_NONE;
  endfunction

  // Advances the decoder state by one body byte and returns the result item it gives.
  function automatic cbd_result_t decode_byte(logic [7:0] b, logic fin);
    cbd_result_t r;
    cbd_phase_e  was;
    logic        hex;
    logic [3:0]  nib;
    logic        ws;

    r.data_byte  = 8'h00;
    r.data_valid = 1'b0;
    r.status     = ST_NONE;
    was          = ph;

    hex = 1'b1;
    nib = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin        // 0-9
      nib = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin // a-f
      nib = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin // A-F
      nib = 4'(b - 8'h41 + 8'd10);
    end else begin
      hex = 1'b0;
    end
    ws = (b == CHR_SP) || (b == CHR_TAB) || (b == CHR_CR) ||
         (b == CHR_VT) || (b == CHR_FF);

    case (ph)
      PH_LSTART: begin
        count_q   = '0;
        had_digit = 1'b0;
        if (b == CHR_LF) begin
        end else if (ws) begin
          ph = PH_WS;
        end else if (hex) begin
          count_q   = SIZE_BITS'(nib);
          had_digit = 1'b1;
          ph        = PH_DIGITS;
        end else begin
          ph = PH_REST;
        end
      end
      PH_WS: begin
        if (b == CHR_LF) begin
          r.status = close_size_line();
        end else if (ws) begin
        end else if (hex) begin
          count_q   = SIZE_BITS'(nib);
          had_digit = 1'b1;
          ph        = PH_DIGITS;
        end else begin
          ph = PH_REST;
        end
      end
      PH_DIGITS: begin
        if (b == CHR_LF) begin
          r.status = close_size_line();
        end else if (hex) begin
          if (count_q[SIZE_BITS-1 -: 4] != 4'h0) begin
            r.status = ST_OVERFLOW;
            ph       = PH_DONE;
          end else begin
            count_q = {count_q[SIZE_BITS-5:0], nib};
          end
        end else begin
          ph = PH_REST;
        end
      end
      PH_REST: begin
        if (b == CHR_LF) r.status = close_size_line();
      end
      PH_DATA: begin
        r.data_valid = 1'b1;
        r.data_byte  = b;
        count_q      = count_q - SIZE_BITS'(1);
        if (count_q == '0) ph = PH_TRAIL;
      end
      PH_TRAIL: begin
        if (b == CHR_LF) ph = PH_LSTART;
      end
      default: begin
      end
    endcase

    if (fin) begin
      case (ph)
        PH_WS, PH_DIGITS, PH_REST: begin
          r.status = (close_size_line() == ST_COMPLETE) ? ST_COMPLETE : ST_TRUNCATED;
        end
        PH_DATA:   r.status = ST_TRUNCATED;
        // no line end can follow when the final byte was the last payload byte
        PH_TRAIL:  r.status = (was == PH_DATA) ? ST_NOLINEEND : ST_COMPLETE;
        PH_LSTART: r.status = ST_COMPLETE;
        default: begin
        end
      endcase
      ph        = PH_LSTART;
      count_q   = '0;
      had_digit = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph        = PH_LSTART;
      count_q   = '0;
      had_digit = 1'b0;
      fails     = 0;
      decoded_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result item: data %02h valid %0d status %0d", $time,
                   out_mon_i.data_byte, out_mon_i.data_valid, out_mon_i.status);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          if (out_mon_i.data_byte !== want.data_byte ||
              out_mon_i.data_valid !== want.data_valid ||
              out_mon_i.status !== want.status) begin
            $display({"%0t: mismatch: expected data %02h valid %0d status %0d, ",
                      "got data %02h valid %0d status %0d"},
                     $time, want.data_byte, want.data_valid, want.status,
                     out_mon_i.data_byte, out_mon_i.data_valid, out_mon_i.status);
            fails++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        decoded_q.push_back(decode_byte(in_mon_i.body_byte, in_mon_i.final_byte));
      end
      pending_o    <= decoded_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ verif/tb_chunked_body_decoder.sv @@
`timescale 1ns / 100ps

module tb_chunked_body_decoder;
  import cbd_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 550;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned sent_items;
  bit          hold_req;
  logic [7:0]  body_q[$];

  cbd_in_if  in_ch();
  cbd_out_if out_ch();

  chunked_body_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cbd_decode_check u_decode_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("FAIL chunked_body_decoder");
    $finish;
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.body_byte  <= b;
    in_ch.final_byte <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // sends body_q up to and including index last, the final flag on that byte
  task automatic send_body(input int unsigned last);
    for (int unsigned i = 0; i <= last; i++) put_byte(body_q[i], i == last);
    sent_items += last + 1;
    body_q.delete();
  endtask

  task automatic add_size_line(input logic [31:0] sz);
    logic started;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(4))
          0:       body_q.push_back(CHR_SP);
          1:       body_q.push_back(CHR_TAB);
          2:       body_q.push_back(CHR_CR);
          3:       body_q.push_back(CHR_VT);
          default: body_q.push_back(CHR_FF);
        endcase
      end
    end
    if ($urandom_range(5) == 0) repeat ($urandom_range(1, 3)) body_q.push_back(8'h30);
    started = 1'b0;
    for (int s = 28; s >= 0; s -= 4) begin
      if (started || sz[s +: 4] != 4'h0 || s == 0) begin
        started = 1'b1;
        body_q.push_back(hex_char(sz[s +: 4]));
      end
    end
    if ($urandom_range(4) == 0) begin
      body_q.push_back(8'h3B); // chunk extension after ';'
      repeat ($urandom_range(0, 4)) body_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
    end
    if ($urandom_range(3) != 0) body_q.push_back(CHR_CR);
    body_q.push_back(CHR_LF);
  endtask

  task automatic build_message();
    int unsigned kind;
    int unsigned sz;
    kind = $urandom_range(99);
    if (kind < 72) begin
      repeat ($urandom_range(1, 4)) begin
        sz = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        if ($urandom_range(7) == 0) body_q.push_back(CHR_LF);
        add_size_line(sz);
        repeat (sz) body_q.push_back(8'($urandom_range(255)));
        // junk before the line end after payload, never a line feed
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range(8'h0B, 8'hFF)));
        end
        if ($urandom_range(3) != 0) body_q.push_back(CHR_CR);
        body_q.push_back(CHR_LF);
      end
      if ($urandom_range(3) == 0) begin
        // last line without a usable size: sign, 0x prefix or no digit at all
        case ($urandom_range(3))
          0: body_q.push_back(8'h2D);
          1: body_q.push_back(8'h2B);
          2: begin
            body_q.push_back(8'h30);
            body_q.push_back(8'h78);
          end
          default: body_q.push_back(8'h3B);
        endcase
        body_q.push_back(hex_char(4'($urandom_range(15))));
        body_q.push_back(CHR_LF);
      end else begin
        add_size_line(0);
      end
      repeat ($urandom_range(0, 6)) body_q.push_back(8'($urandom_range(255)));
      if (kind >= 60) body_q[$urandom_range(body_q.size() - 1)] = 8'($urandom_range(255));
    end else if (kind < 86) begin
      repeat ($urandom_range(0, 2)) body_q.push_back(8'h30);
      body_q.push_back(hex_char(4'($urandom_range(1, 15))));
      repeat ($urandom_range(7, 10)) body_q.push_back(hex_char(4'($urandom_range(15))));
      body_q.push_back(CHR_CR);
      body_q.push_back(CHR_LF);
      repeat ($urandom_range(0, 5)) body_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(1)) body_q.push_back(8'($urandom_range(255)));
        else if ($urandom_range(3) == 0) body_q.push_back(CHR_LF);
        else body_q.push_back(hex_char(4'($urandom_range(15))));
      end
    end
  endtask

  task automatic run_bodies(input int unsigned n);
    int unsigned target;
    int unsigned last;
    target = sent_items + n;
    while (sent_items < target) begin
      build_message();
      last = body_q.size() - 1;
      if ($urandom_range(3) == 0) last = $urandom_range(body_q.size() - 1);
      send_body(last);
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.body_byte  <= 8'h00;
    in_ch.final_byte <= 1'b0;
    hold_req      = 1'b0;
    sent_items    = 0;
    send_idle_pct = 13;
    recv_idle_pct = 70;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty line, leading tab, extension, payload 00/FF, final in the trailing CR
    body_q = '{CHR_LF, CHR_TAB, 8'h32, 8'h3B, CHR_LF, 8'h00, 8'hFF, CHR_CR};
    send_body(body_q.size() - 1);
    // final on the last payload byte: no line end
    body_q = '{8'h31, CHR_LF, 8'h41};
    send_body(body_q.size() - 1);
    // final with payload still owed
    body_q = '{8'h33, CHR_LF, 8'h55};
    send_body(body_q.size() - 1);
    // 0x prefix reads as size zero, then a byte after completion
    body_q = '{8'h30, 8'h78, 8'h35, CHR_LF, 8'h7F};
    send_body(body_q.size() - 1);
    // final inside a size line with and without digits, and at a line start
    body_q = '{8'h46};
    send_body(0);
    body_q = '{8'h2D};
    send_body(0);
    body_q = '{CHR_LF};
    send_body(0);
    // nine digits overflow a 32-bit size
    body_q = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, CHR_SP};
    send_body(body_q.size() - 1);

    run_bodies(PHASE_ITEMS);
    send_idle_pct = 70;
    recv_idle_pct = 13;
    run_bodies(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_bodies(PHASE_ITEMS);

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS chunked_body_decoder");
    end else begin
      $display("FAIL chunked_body_decoder");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cbd_pkg.sv
rtl/cbd_if.sv
rtl/cbd_parse.sv
rtl/chunked_body_decoder.sv
verif/cbd_decode_check.sv
verif/tb_chunked_body_decoder.sv
